FILE: rtl/bfa_pkg.sv
`default_nettype none
package bfa_pkg;

    localparam int DEF_TX_WORDS    = 16;
    localparam int DEF_RX_WORDS    = 16;
    localparam int REG_WINDOW_BASE = 1024;
    localparam int ACC_WINDOW_BASE = 2048;

    localparam int WORD_W     = 15;
    localparam int IN_W       = 120;
    localparam int IN_USER_W  = 2;
    localparam int OUT_W      = 104;
    localparam int OUT_USER_W = 1;

    localparam logic [WORD_W-1:0] REG_WORD = WORD_W'(REG_WINDOW_BASE / 4);
    localparam logic [WORD_W-1:0] ACC_WORD = WORD_W'(ACC_WINDOW_BASE / 4);

    localparam logic [7:0]  UPPER_BE_MASK = 8'hF0;
    localparam logic [31:0] ALL_ONES      = '1;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_FLIT  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_SEND  = 2'd0,
        REG_DONE  = 2'd1,
        REG_EMPTY = 2'd2,
        REG_FULL  = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEND
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic load_resp;
        logic tx_rd_first;
        logic load_flit;
        logic send_end;
    } t_cmd;

    typedef struct packed {
        logic bus_req;
        logic req_send;
        logic out_free;
        logic idx_last;
    } t_sts;

endpackage
`default_nettype wire

FILE: rtl/bfa_ctrl.sv
`default_nettype none
module bfa_ctrl (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  bfa_pkg::t_sts i_sts,
    output bfa_pkg::t_cmd o_cmd
);
    import bfa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_sts.bus_req) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.req_send ? ST_SEND : ST_IDLE;
                end
            end
            ST_SEND: begin
                if (i_sts.out_free && i_sts.idx_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
            end
            ST_EXEC: begin
                o_cmd.load_resp   = i_sts.out_free;
                o_cmd.tx_rd_first = i_sts.out_free && i_sts.req_send;
            end
            ST_SEND: begin
                o_cmd.load_flit = i_sts.out_free;
                o_cmd.send_end  = i_sts.out_free && i_sts.idx_last;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/bfa_dp.sv
`default_nettype none
module bfa_dp #(
    parameter int TX_WORDS = bfa_pkg::DEF_TX_WORDS,
    parameter int RX_WORDS = bfa_pkg::DEF_RX_WORDS
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_tvalid,
    input  wire  [bfa_pkg::IN_W-1:0]       i_tdata,
    input  wire  [bfa_pkg::IN_USER_W-1:0]  i_tuser,
    input  wire                            i_tlast,
    output logic                           o_tvalid,
    input  wire                            i_tready,
    output logic [bfa_pkg::OUT_W-1:0]      o_tdata,
    output logic [bfa_pkg::OUT_USER_W-1:0] o_tuser,
    output logic                           o_tlast,
    input  bfa_pkg::t_cmd                  i_cmd,
    output bfa_pkg::t_sts                  o_sts
);
    import bfa_pkg::*;

    localparam int TX_AW = (TX_WORDS > 1) ? $clog2(TX_WORDS) : 1;
    localparam int RX_AW = (RX_WORDS > 1) ? $clog2(RX_WORDS) : 1;
    localparam int CNT_W = $clog2(RX_WORDS + 1);

    logic [31:0] tx_mem [TX_WORDS];
    logic [31:0] rx_mem [RX_WORDS];

    logic [15:0]       byte_address;
    logic [7:0]        byte_enable;
    logic [63:0]       write_data;
    logic [31:0]       flit_in_data;
    t_mode             mode;
    logic              accept;
    logic              upper;
    logic [WORD_W-1:0] word;
    logic [31:0]       value;
    logic              is_acc;
    logic              is_reg;
    logic              tx_in_range;
    logic              rx_in_range;
    logic              rx_room;
    logic              wr_acc;
    logic              rd_acc;
    logic              fl_acc;
    logic [31:0]       rval;
    logic              rd_mem;
    logic              rd_err;
    logic              tx_rd_en;
    logic [TX_AW-1:0]  tx_rd_addr;
    logic              idx_last;
    logic [31:0]       resp32;

    logic              r_done;
    logic              r_full;
    logic              r_armed;
    logic [CNT_W-1:0]  r_count;
    logic [TX_AW-1:0]  r_idx;
    logic              r_req_send;
    logic              r_req_read;
    logic              r_req_upper;
    logic              r_req_err;
    logic              r_req_mem;
    logic [31:0]       r_req_rval;
    logic [31:0]       r_tx_rdata;
    logic [31:0]       r_rx_rdata;
    logic              r_out_valid;
    logic              r_out_kind;
    logic [63:0]       r_out_rdata;
    logic              r_out_err;
    logic [31:0]       r_out_fdata;
    logic              r_out_head;
    logic              r_out_tail;
    logic              r_out_last;

    assign byte_address = i_tdata[15:0];
    assign byte_enable  = i_tdata[23:16];
    assign write_data   = i_tdata[87:24];
    assign flit_in_data = i_tdata[119:88];
    assign mode         = t_mode'(i_tuser);

    assign accept = i_tvalid && i_cmd.in_ready;
    assign wr_acc = accept && (mode == MODE_WRITE);
    assign rd_acc = accept && (mode == MODE_READ);
    assign fl_acc = accept && (mode == MODE_FLIT);

    assign upper       = (byte_enable & UPPER_BE_MASK) != 8'h00;
    assign word        = WORD_W'(byte_address[15:2]) + WORD_W'(upper);
    assign value       = upper ? write_data[63:32] : write_data[31:0];
    assign is_acc      = word >= ACC_WORD;
    assign is_reg      = !is_acc && (word >= REG_WORD);
    assign tx_in_range = word < WORD_W'(TX_WORDS);
    assign rx_in_range = word < WORD_W'(RX_WORDS);
    assign rx_room     = r_count < CNT_W'(RX_WORDS);

    always_comb begin
        rval   = ALL_ONES;
        rd_mem = 1'b0;
        rd_err = 1'b0;
        if (is_acc) begin
            rval = ALL_ONES;
        end else if (is_reg) begin
            if (word == REG_WORD + WORD_W'(REG_DONE)) begin
                rval = {31'd0, r_done};
            end else if (word == REG_WORD + WORD_W'(REG_FULL)) begin
                rval = {31'd0, r_full};
            end
        end else if (mode == MODE_WRITE) begin
            rd_err = !tx_in_range;
        end else if (rx_in_range) begin
            rd_mem = 1'b1;
        end else begin
            rd_err = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_acc && !is_acc && !is_reg && tx_in_range) begin
            tx_mem[word[TX_AW-1:0]] <= value;
        end
        if (tx_rd_en) begin
            r_tx_rdata <= tx_mem[tx_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fl_acc && r_armed && rx_room) begin
            rx_mem[r_count[RX_AW-1:0]] <= flit_in_data;
        end
        if (rd_acc && !is_acc && !is_reg && rx_in_range) begin
            r_rx_rdata <= rx_mem[word[RX_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done     <= 1'b1;
            r_full     <= 1'b0;
            r_armed    <= 1'b0;
            r_count    <= '0;
            r_req_send <= 1'b0;
        end else begin
            if (accept && (mode == MODE_WRITE || mode == MODE_READ)) begin
                r_req_send <= wr_acc && is_reg && (word == REG_WORD + WORD_W'(REG_SEND));
            end
            if (wr_acc && is_reg) begin
                if (word == REG_WORD + WORD_W'(REG_SEND)) begin
                    r_done <= 1'b0;
                end else if (word == REG_WORD + WORD_W'(REG_EMPTY)) begin
                    r_full  <= 1'b0;
                    r_armed <= 1'b1;
                    r_count <= '0;
                end
            end
            if (fl_acc && r_armed) begin
                if (rx_room) begin
                    r_count <= r_count + CNT_W'(1);
                end
                if (i_tlast) begin
                    r_full  <= 1'b1;
                    r_armed <= 1'b0;
                end
            end
            if (i_cmd.send_end) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_read  <= mode == MODE_READ;
            r_req_upper <= upper;
            r_req_err   <= rd_err;
            r_req_mem   <= rd_mem;
            r_req_rval  <= rval;
        end
    end

    assign idx_last   = r_idx == TX_AW'(TX_WORDS - 1);
    assign tx_rd_en   = i_cmd.tx_rd_first || (i_cmd.load_flit && !idx_last);
    assign tx_rd_addr = i_cmd.tx_rd_first ? '0 : r_idx + TX_AW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.tx_rd_first) begin
            r_idx <= '0;
        end else if (i_cmd.load_flit) begin
            r_idx <= r_idx + TX_AW'(1);
        end
    end

    assign resp32 = r_req_mem ? r_rx_rdata : r_req_rval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_resp || i_cmd.load_flit) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_resp) begin
            r_out_kind  <= 1'b0;
            r_out_err   <= r_req_err;
            r_out_fdata <= '0;
            r_out_head  <= 1'b0;
            r_out_tail  <= 1'b0;
            r_out_last  <= !r_req_send;
            if (!r_req_read) begin
                r_out_rdata <= '0;
            end else if (r_req_upper) begin
                r_out_rdata <= {resp32, 32'd0};
            end else begin
                r_out_rdata <= {32'd0, resp32};
            end
        end else if (i_cmd.load_flit) begin
            r_out_kind  <= 1'b1;
            r_out_rdata <= '0;
            r_out_err   <= 1'b0;
            r_out_fdata <= r_tx_rdata;
            r_out_head  <= r_idx == '0;
            r_out_tail  <= idx_last;
            r_out_last  <= idx_last;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {5'd0, r_out_tail, r_out_head, r_out_fdata, r_out_err, r_out_rdata};
    assign o_tuser  = r_out_kind;
    assign o_tlast  = r_out_last;

    assign o_sts.bus_req  = i_tvalid && (mode == MODE_WRITE || mode == MODE_READ);
    assign o_sts.req_send = r_req_send;
    assign o_sts.out_free = !r_out_valid || i_tready;
    assign o_sts.idx_last = idx_last;

endmodule
`default_nettype wire

FILE: rtl/bus_to_flit_packet_adapter_unit.sv
// Channel   Dir  tdata (low bit up)                                    tuser   tlast
// s_axis    in   byte_address[16] byte_enable[8] write_data[64]        mode    flit_in_tail
//                flit_in_data[32]
// m_axis    out  read_data[64] bus_error flit_out_data[32]             kind    last
//                flit_out_head flit_out_tail (pad to 104)
//
// Flit arrivals are taken in the idle state and leave the block ready for input.
// A bus access decodes and reads the buffer memory when taken; the execute state then
// loads the output register. A send write streams TX_WORDS flits from the transmit
// memory, one flit per cycle while m_axis does not stall. No input is taken in the
// execute state or during a send; a result still waiting on m_axis stalls both.
// Sync active-low reset sets done, clears other flags, state, output valid; buffers kept.
`default_nettype none
module bus_to_flit_packet_adapter_unit #(
    parameter int TX_WORDS = bfa_pkg::DEF_TX_WORDS,
    parameter int RX_WORDS = bfa_pkg::DEF_RX_WORDS
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    // byte_address, byte_enable, write_data, flit_in_data
    input  wire  [bfa_pkg::IN_W-1:0]       s_axis_tdata,
    // mode
    input  wire  [bfa_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input  wire                            s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    // read_data, bus_error, flit_out_data, flit_out_head, flit_out_tail, zero pad
    output logic [bfa_pkg::OUT_W-1:0]      m_axis_tdata,
    // kind
    output logic [bfa_pkg::OUT_USER_W-1:0] m_axis_tuser,
    output logic                           m_axis_tlast
);
    import bfa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bfa_dp #(
        .TX_WORDS (TX_WORDS),
        .RX_WORDS (RX_WORDS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .i_tlast  (s_axis_tlast),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast),
        .i_cmd    (cmd),
        .o_sts    (sts)
    );

    assign s_axis_tready = cmd.in_ready;

endmodule
`default_nettype wire

FILE: rtl/bfa_checker.sv
`default_nettype none
module bfa_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            s_axis_tready,
    input wire                            m_axis_tvalid,
    input wire                            m_axis_tready,
    input wire [bfa_pkg::OUT_W-1:0]       m_axis_tdata,
    input wire [bfa_pkg::OUT_USER_W-1:0]  m_axis_tuser,
    input wire                            m_axis_tlast
);
    import bfa_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_tail_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] && m_axis_tdata[98] |-> m_axis_tlast)
        else $error("tail flit not marked last");

    a_resp_no_flit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[98:65] == '0)
        else $error("bus response carries flit fields");

    a_busy_in_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken while packet streams");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output changed");

endmodule

bind bus_to_flit_packet_adapter_unit bfa_checker u_bfa_checker (.*);
`default_nettype wire
